>>> rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers shared by the pose transform RTL. They expand
// to nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPFT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");
`define PPFT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");
`else
`define PPFT_ASSERT(lbl, clk, rst, prop)
`define PPFT_NEVER(lbl, clk, rst, prop)
`endif
`endif

>>> rtl/ppft_pkg.sv
// ============================================================================
// Pose transform package
// Widths, constants and types shared by the planar pose transform pipeline.
// ============================================================================
package ppft_pkg;

   localparam int POS_BITS      = 32;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int FRAC       = 30;
   localparam int ZW         = 32;
   localparam int CW         = FRAC + 2;
   localparam int XW         = FRAC + 3;
   localparam int AW         = POS_BITS + 1;
   localparam int HW         = ANGLE_BITS + 1;
   localparam int ATAN_DEPTH = 32;
   localparam int ATAN_IDX_W = 5;
   localparam int LATENCY    = CORDIC_STAGES + 6;

   localparam logic signed [CW-1:0] Q_ONE = {2'b01, {FRAC{1'b0}}};
   localparam logic signed [CW-1:0] Q_NEG = {2'b11, {FRAC{1'b0}}};
   localparam logic signed [CW-1:0] GAIN  = CW'(652032874);

   localparam logic [ZW-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   typedef enum logic {
      KIND_TO_WORLD,
      KIND_TO_BASE
   } kind_type;

   typedef enum logic [1:0] {
      QUAD_EAST,
      QUAD_NORTH,
      QUAD_WEST,
      QUAD_SOUTH
   } quad_type;

   typedef struct packed {
      kind_type                   kind;
      quad_type                   quad;
      logic signed [AW-1:0]       a;
      logic signed [AW-1:0]       b;
      logic signed [POS_BITS-1:0] ox;
      logic signed [POS_BITS-1:0] oy;
      logic signed [HW-1:0]       heading;
   } ctx_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } rot_type;

endpackage

>>> rtl/ppft_prep.sv
// ============================================================================
// Pose transform front end
// Splits the base heading into quadrant and residual angle, forms the operands
// for the selected direction and wraps the result heading.
// ============================================================================
module ppft_prep (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  req_kind,
   input  logic signed [ppft_pkg::POS_BITS-1:0]  req_base_x,
   input  logic signed [ppft_pkg::POS_BITS-1:0]  req_base_y,
   input  logic signed [ppft_pkg::ANGLE_BITS-1:0] req_base_heading,
   input  logic signed [ppft_pkg::POS_BITS-1:0]  req_pt_x,
   input  logic signed [ppft_pkg::POS_BITS-1:0]  req_pt_y,
   input  logic signed [ppft_pkg::ANGLE_BITS-1:0] req_pt_heading,
   output logic                                  dn_valid,
   output ppft_pkg::ctx_type                     dn_ctx,
   output ppft_pkg::rot_type                     dn_rot
);

   localparam int ZW = ppft_pkg::ZW;
   localparam int AB = ppft_pkg::ANGLE_BITS;
   localparam int AW = ppft_pkg::AW;
   localparam int XW = ppft_pkg::XW;
   localparam logic [ZW-1:0] QUARTER_ROUND = {3'b001, {(ZW - 3){1'b0}}};

   logic              valid_ff;
   ppft_pkg::ctx_type ctx_ff;
   ppft_pkg::ctx_type ctx_in;
   ppft_pkg::rot_type rot_ff;
   ppft_pkg::rot_type rot_in;
   logic [ZW-1:0]     z_full;
   logic [ZW-1:0]     z_round;
   logic [ZW-1:0]     z_resid;
   logic [AB-1:0]     head_sum;
   logic              to_base;

   always_comb begin
      to_base  = (ppft_pkg::kind_type'(req_kind) == ppft_pkg::KIND_TO_BASE);
      z_full   = {req_base_heading, {(ZW - AB){1'b0}}};
      z_round  = z_full + QUARTER_ROUND;
      z_resid  = z_full - {z_round[ZW-1:ZW-2], {(ZW - 2){1'b0}}};
      head_sum = to_base ? (req_pt_heading - req_base_heading)
                         : (req_base_heading + req_pt_heading);

      ctx_in.kind    = ppft_pkg::kind_type'(req_kind);
      ctx_in.quad    = ppft_pkg::quad_type'(z_round[ZW-1:ZW-2]);
      ctx_in.a       = to_base ? (AW'(req_pt_x) - AW'(req_base_x)) : AW'(req_pt_x);
      ctx_in.b       = to_base ? (AW'(req_pt_y) - AW'(req_base_y)) : AW'(req_pt_y);
      ctx_in.ox      = to_base ? '0 : req_base_x;
      ctx_in.oy      = to_base ? '0 : req_base_y;
      ctx_in.heading = {head_sum[AB-1] & (|head_sum[AB-2:0]), head_sum};

      rot_in.x = XW'(ppft_pkg::Q_ONE);
      rot_in.y = '0;
      rot_in.z = $signed(z_resid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff <= ctx_in;
      rot_ff <= rot_in;
   end

   assign dn_valid = valid_ff;
   assign dn_ctx   = ctx_ff;
   assign dn_rot   = rot_ff;

endmodule

>>> rtl/ppft_cordic_cell.sv
// ============================================================================
// CORDIC cell
// One rotation-mode micro-rotation; hands its vector, residual angle and the
// pose context to the next cell every cycle.
// ============================================================================
module ppft_cordic_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ppft_pkg::ATAN_IDX_W-1:0]    stage,
   input  logic                               up_valid,
   input  ppft_pkg::ctx_type                  up_ctx,
   input  ppft_pkg::rot_type                  up_rot,
   output logic                               dn_valid,
   output ppft_pkg::ctx_type                  dn_ctx,
   output ppft_pkg::rot_type                  dn_rot
);

   localparam int XW = ppft_pkg::XW;
   localparam int ZW = ppft_pkg::ZW;

   logic                 valid_ff;
   ppft_pkg::ctx_type    ctx_ff;
   ppft_pkg::rot_type    rot_ff;
   ppft_pkg::rot_type    rot_in;
   logic signed [XW-1:0] x_shift;
   logic signed [XW-1:0] y_shift;
   logic signed [ZW-1:0] step;

   always_comb begin
      x_shift = up_rot.x >>> stage;
      y_shift = up_rot.y >>> stage;
      step    = $signed(ppft_pkg::ATAN_TABLE[stage]);
      if (!up_rot.z[ZW-1]) begin
         rot_in.x = up_rot.x - y_shift;
         rot_in.y = up_rot.y + x_shift;
         rot_in.z = up_rot.z - step;
      end else begin
         rot_in.x = up_rot.x + y_shift;
         rot_in.y = up_rot.y - x_shift;
         rot_in.z = up_rot.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff <= up_ctx;
      rot_ff <= rot_in;
   end

   assign dn_valid = valid_ff;
   assign dn_ctx   = ctx_ff;
   assign dn_rot   = rot_ff;

endmodule

>>> rtl/ppft_post.sv
// ============================================================================
// Pose transform back end
// Applies the CORDIC gain, restores the quadrant, multiplies the positions by
// cosine and sine, rounds, sums and saturates the result word.
// ============================================================================
`include "assert_macros.svh"

module ppft_post (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   input  ppft_pkg::ctx_type                   up_ctx,
   input  ppft_pkg::rot_type                   up_rot,
   output logic                                rsp_valid,
   output logic signed [ppft_pkg::POS_BITS-1:0] rsp_out_x,
   output logic signed [ppft_pkg::POS_BITS-1:0] rsp_out_y,
   output logic signed [ppft_pkg::HW-1:0]      rsp_out_heading,
   output logic                                rsp_saturated
);

   localparam int FRAC = ppft_pkg::FRAC;
   localparam int PB   = ppft_pkg::POS_BITS;
   localparam int CW   = ppft_pkg::CW;
   localparam int XW   = ppft_pkg::XW;
   localparam int AW   = ppft_pkg::AW;
   localparam int HW   = ppft_pkg::HW;
   localparam int GPW  = XW + CW;
   localparam int GRW  = GPW - FRAC;
   localparam int PW   = AW + CW;
   localparam int RW   = PW - FRAC;
   localparam int SW   = RW + 2;
   localparam logic signed [PB-1:0] POS_MAX  = {1'b0, {(PB - 1){1'b1}}};
   localparam logic signed [PB-1:0] POS_MIN  = {1'b1, {(PB - 1){1'b0}}};
   localparam logic signed [HW-1:0] HEAD_NEG = {2'b11, {(HW - 2){1'b0}}};

   function automatic logic signed [GRW-1:0] round_gain(input logic signed [GPW-1:0] p);
      logic signed [GPW-1:0] s;
      s = p + $signed({{(GPW - FRAC){1'b0}}, ~p[GPW-1], {(FRAC - 1){p[GPW-1]}}});
      return s[GPW-1:FRAC];
   endfunction

   function automatic logic signed [RW-1:0] round_prod(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = p + $signed({{(PW - FRAC){1'b0}}, ~p[PW-1], {(FRAC - 1){p[PW-1]}}});
      return s[PW-1:FRAC];
   endfunction

   function automatic logic signed [CW-1:0] clamp_unit(input logic signed [GRW-1:0] g);
      logic signed [CW-1:0] r;
      if (g > GRW'(ppft_pkg::Q_ONE)) begin
         r = ppft_pkg::Q_ONE;
      end else if (g < GRW'(ppft_pkg::Q_NEG)) begin
         r = ppft_pkg::Q_NEG;
      end else begin
         r = CW'(g);
      end
      return r;
   endfunction

   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   ppft_pkg::ctx_type     s1_ctx_ff, s2_ctx_ff, s3_ctx_ff, s4_ctx_ff;
   logic signed [GPW-1:0] gx_ff, gy_ff;
   logic signed [CW-1:0]  co_ff, si_ff, co_in, si_in;
   logic signed [CW-1:0]  cx, cy;
   logic signed [PW-1:0]  pac_ff, pbs_ff, pas_ff, pbc_ff;
   logic signed [RW-1:0]  tac_ff, tbs_ff, tas_ff, tbc_ff;
   logic signed [SW-1:0]  sum_x, sum_y;
   logic signed [PB-1:0]  out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic signed [HW-1:0]  out_heading_ff;
   logic                  saturated_ff, saturated_in;

   always_comb begin
      cx = clamp_unit(round_gain(gx_ff));
      cy = clamp_unit(round_gain(gy_ff));
      case (s1_ctx_ff.quad)
         ppft_pkg::QUAD_EAST: begin
            co_in = cx;
            si_in = cy;
         end
         ppft_pkg::QUAD_NORTH: begin
            co_in = -cy;
            si_in = cx;
         end
         ppft_pkg::QUAD_WEST: begin
            co_in = -cx;
            si_in = -cy;
         end
         default: begin
            co_in = cy;
            si_in = -cx;
         end
      endcase
      if (s1_ctx_ff.kind == ppft_pkg::KIND_TO_BASE) begin
         si_in = -si_in;
      end
   end

   always_comb begin
      sum_x = SW'(s4_ctx_ff.ox) + SW'(tac_ff) - SW'(tbs_ff);
      sum_y = SW'(s4_ctx_ff.oy) + SW'(tas_ff) + SW'(tbc_ff);
      saturated_in = 1'b0;
      out_x_in = PB'(sum_x);
      out_y_in = PB'(sum_y);
      if (sum_x > SW'(POS_MAX)) begin
         out_x_in     = POS_MAX;
         saturated_in = 1'b1;
      end else if (sum_x < SW'(POS_MIN)) begin
         out_x_in     = POS_MIN;
         saturated_in = 1'b1;
      end
      if (sum_y > SW'(POS_MAX)) begin
         out_y_in     = POS_MAX;
         saturated_in = 1'b1;
      end else if (sum_y < SW'(POS_MIN)) begin
         out_y_in     = POS_MIN;
         saturated_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= up_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctx_ff      <= up_ctx;
      gx_ff          <= GPW'(up_rot.x) * GPW'(ppft_pkg::GAIN);
      gy_ff          <= GPW'(up_rot.y) * GPW'(ppft_pkg::GAIN);
      s2_ctx_ff      <= s1_ctx_ff;
      co_ff          <= co_in;
      si_ff          <= si_in;
      s3_ctx_ff      <= s2_ctx_ff;
      pac_ff         <= PW'(s2_ctx_ff.a) * PW'(co_ff);
      pbs_ff         <= PW'(s2_ctx_ff.b) * PW'(si_ff);
      pas_ff         <= PW'(s2_ctx_ff.a) * PW'(si_ff);
      pbc_ff         <= PW'(s2_ctx_ff.b) * PW'(co_ff);
      s4_ctx_ff      <= s3_ctx_ff;
      tac_ff         <= round_prod(pac_ff);
      tbs_ff         <= round_prod(pbs_ff);
      tas_ff         <= round_prod(pas_ff);
      tbc_ff         <= round_prod(pbc_ff);
      out_x_ff       <= out_x_in;
      out_y_ff       <= out_y_in;
      out_heading_ff <= s4_ctx_ff.heading;
      saturated_ff   <= saturated_in;
   end

   assign rsp_valid       = s5_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_out_heading = out_heading_ff;
   assign rsp_saturated   = saturated_ff;

   `PPFT_ASSERT(a_unit_range, clock, reset, s2_valid_ff |-> (co_ff <= ppft_pkg::Q_ONE && co_ff >= ppft_pkg::Q_NEG && si_ff <= ppft_pkg::Q_ONE && si_ff >= ppft_pkg::Q_NEG))
   `PPFT_ASSERT(a_sat_rail, clock, reset, (rsp_valid && rsp_saturated) |-> (rsp_out_x == POS_MAX || rsp_out_x == POS_MIN || rsp_out_y == POS_MAX || rsp_out_y == POS_MIN))
   `PPFT_NEVER(a_no_neg_half, clock, reset, rsp_valid && rsp_out_heading == HEAD_NEG)

endmodule

>>> rtl/planar_pose_frame_transform_core.sv
// ============================================================================
// Planar pose frame transform core
// Rigid SE(2) transform of a point pose between a base frame and the world
// frame, with CORDIC sine and cosine and saturating Q16.16 positions.
//
//   channel   ports                          handshake
//   request   start, busy, req_*             start high while busy low
//   response  rsp_valid, rsp_*               one-cycle strobe, no backpressure
//
// A pose enters every cycle; its result word is formed by the front register,
// the chain of CORDIC cells and the five multiply, round and saturate stages
// that follow it. busy stays low. Synchronous reset clears only the valid bits
// of the pipeline; words in flight at reset are dropped.
// ============================================================================
`include "assert_macros.svh"

module planar_pose_frame_transform_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_kind,
   input  logic signed [ppft_pkg::POS_BITS-1:0]  req_base_x,
   input  logic signed [ppft_pkg::POS_BITS-1:0]  req_base_y,
   input  logic signed [ppft_pkg::ANGLE_BITS-1:0] req_base_heading,
   input  logic signed [ppft_pkg::POS_BITS-1:0]  req_pt_x,
   input  logic signed [ppft_pkg::POS_BITS-1:0]  req_pt_y,
   input  logic signed [ppft_pkg::ANGLE_BITS-1:0] req_pt_heading,
   output logic                                  rsp_valid,
   output logic signed [ppft_pkg::POS_BITS-1:0]  rsp_out_x,
   output logic signed [ppft_pkg::POS_BITS-1:0]  rsp_out_y,
   output logic signed [ppft_pkg::HW-1:0]        rsp_out_heading,
   output logic                                  rsp_saturated
);

   localparam int NS = ppft_pkg::CORDIC_STAGES;

   logic              accept;
   logic              chain_valid [NS + 1];
   ppft_pkg::ctx_type chain_ctx   [NS + 1];
   ppft_pkg::rot_type chain_rot   [NS + 1];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ppft_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_kind         (req_kind),
      .req_base_x       (req_base_x),
      .req_base_y       (req_base_y),
      .req_base_heading (req_base_heading),
      .req_pt_x         (req_pt_x),
      .req_pt_y         (req_pt_y),
      .req_pt_heading   (req_pt_heading),
      .dn_valid         (chain_valid[0]),
      .dn_ctx           (chain_ctx[0]),
      .dn_rot           (chain_rot[0])
   );

   for (genvar k = 0; k < NS; k++) begin : g_cell
      ppft_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .stage    (ppft_pkg::ATAN_IDX_W'(k)),
         .up_valid (chain_valid[k]),
         .up_ctx   (chain_ctx[k]),
         .up_rot   (chain_rot[k]),
         .dn_valid (chain_valid[k + 1]),
         .dn_ctx   (chain_ctx[k + 1]),
         .dn_rot   (chain_rot[k + 1])
      );
   end

   ppft_post u_post (
      .clock           (clock),
      .reset           (reset),
      .up_valid        (chain_valid[NS]),
      .up_ctx          (chain_ctx[NS]),
      .up_rot          (chain_rot[NS]),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_heading (rsp_out_heading),
      .rsp_saturated   (rsp_saturated)
   );

   `PPFT_ASSERT(a_word_emerges, clock, reset, accept |-> ##(ppft_pkg::LATENCY) rsp_valid)
   `PPFT_ASSERT(a_word_has_source, clock, reset, rsp_valid |-> $past(accept, ppft_pkg::LATENCY))

endmodule

>>> test/pose_transform_checker.sv
// ----------------------------------------------------------------------------
// Pose transform checker
// Watches the request and result channels of the planar pose frame transform
// core. Every accepted pose is run through a fixed-point model of the SE(2)
// transform (CORDIC sine and cosine, rounded products, saturated sums and a
// wrapped heading), and every result word is compared field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pose_transform_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic                                   req_kind,
   input  logic signed [ppft_pkg::POS_BITS-1:0]   req_base_x,
   input  logic signed [ppft_pkg::POS_BITS-1:0]   req_base_y,
   input  logic signed [ppft_pkg::ANGLE_BITS-1:0] req_base_heading,
   input  logic signed [ppft_pkg::POS_BITS-1:0]   req_pt_x,
   input  logic signed [ppft_pkg::POS_BITS-1:0]   req_pt_y,
   input  logic signed [ppft_pkg::ANGLE_BITS-1:0] req_pt_heading,
   input  logic                                   rsp_valid,
   input  logic signed [ppft_pkg::POS_BITS-1:0]   rsp_out_x,
   input  logic signed [ppft_pkg::POS_BITS-1:0]   rsp_out_y,
   input  logic signed [ppft_pkg::HW-1:0]         rsp_out_heading,
   input  logic                                   rsp_saturated,
   output int                                     mismatch_count,
   output int                                     poses_in_flight,
   output int                                     results_checked,
   output int                                     results_clipped
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PB = ppft_pkg::POS_BITS;
   localparam int AB = ppft_pkg::ANGLE_BITS;
   localparam int HW = ppft_pkg::HW;

   typedef struct {
      logic signed [PB-1:0] x;
      logic signed [PB-1:0] y;
      logic signed [HW-1:0] heading;
      logic                 clipped;
   } pose_result_type;

   localparam longint UNIT_Q30    = longint'(1) << 30;
   localparam longint CORDIC_GAIN = 652032874;

   localparam logic [31:0] ARCTAN_STEP [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   pose_result_type expected_poses [$];

   function automatic longint scale_q30(longint a, longint c);
      logic        negative;
      logic [95:0] ua;
      logic [95:0] uc;
      logic [95:0] product;
      negative = (a < 0) != (c < 0);
      ua = (a < 0) ? -a : a;
      uc = (c < 0) ? -c : c;
      product = (ua * uc + (96'd1 << 29)) >> 30;
      return negative ? -longint'(product[63:0]) : longint'(product[63:0]);
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > UNIT_Q30) return UNIT_Q30;
      if (v < -UNIT_Q30) return -UNIT_Q30;
      return v;
   endfunction

   function automatic void heading_sincos(input logic [AB-1:0] heading,
                                          output longint cos_q30,
                                          output longint sin_q30);
      logic [31:0]        z32;
      logic [31:0]        residual;
      ppft_pkg::quad_type quad;
      longint             cx;
      longint             cy;
      longint             z;
      longint             xs;
      longint             ys;
      longint             step;
      z32 = 32'(heading) << (32 - AB);
      quad = ppft_pkg::quad_type'(2'((z32 + 32'h2000_0000) >> 30));
      residual = z32 - {quad, 30'd0};
      z = longint'($signed(residual));
      cx = UNIT_Q30;
      cy = 0;
      for (int i = 0; i < ppft_pkg::CORDIC_STAGES; i++) begin
         step = (i < 32) ? longint'(ARCTAN_STEP[i % 32]) : 0;
         xs = cx >>> ((i < 63) ? i : 63);
         ys = cy >>> ((i < 63) ? i : 63);
         if (z >= 0) begin
            cx -= ys;
            cy += xs;
            z -= step;
         end else begin
            cx += ys;
            cy -= xs;
            z += step;
         end
      end
      cx = clamp_unit(scale_q30(cx, CORDIC_GAIN));
      cy = clamp_unit(scale_q30(cy, CORDIC_GAIN));
      case (quad)
         ppft_pkg::QUAD_EAST: begin
            cos_q30 = cx;
            sin_q30 = cy;
         end
         ppft_pkg::QUAD_NORTH: begin
            cos_q30 = -cy;
            sin_q30 = cx;
         end
         ppft_pkg::QUAD_WEST: begin
            cos_q30 = -cx;
            sin_q30 = -cy;
         end
         default: begin
            cos_q30 = cy;
            sin_q30 = -cx;
         end
      endcase
   endfunction

   function automatic longint clip_position(longint v, inout logic clipped);
      longint limit;
      limit = longint'(1) << (PB - 1);
      if (v > limit - 1) begin
         clipped = 1'b1;
         return limit - 1;
      end
      if (v < -limit) begin
         clipped = 1'b1;
         return -limit;
      end
      return v;
   endfunction

   function automatic pose_result_type transform_pose(
      ppft_pkg::kind_type   kind,
      logic signed [PB-1:0] bx,
      logic signed [PB-1:0] by,
      logic signed [AB-1:0] bh,
      logic signed [PB-1:0] px,
      logic signed [PB-1:0] py,
      logic signed [AB-1:0] ph);
      pose_result_type r;
      longint          co;
      longint          si;
      longint          rx;
      longint          ry;
      longint          dx;
      longint          dy;
      longint          turn_sum;
      longint          full_turn;
      longint          wrapped;
      logic            clipped;
      heading_sincos(bh, co, si);
      if (kind == ppft_pkg::KIND_TO_WORLD) begin
         rx = longint'(bx) + scale_q30(px, co) - scale_q30(py, si);
         ry = longint'(by) + scale_q30(px, si) + scale_q30(py, co);
         turn_sum = longint'(bh) + longint'(ph);
      end else begin
         dx = longint'(px) - longint'(bx);
         dy = longint'(py) - longint'(by);
         rx = scale_q30(dx, co) + scale_q30(dy, si);
         ry = scale_q30(dy, co) - scale_q30(dx, si);
         turn_sum = longint'(ph) - longint'(bh);
      end
      clipped = 1'b0;
      rx = clip_position(rx, clipped);
      ry = clip_position(ry, clipped);
      full_turn = longint'(1) << AB;
      wrapped = turn_sum & (full_turn - 1);
      if (wrapped > (full_turn >> 1))
         wrapped -= full_turn;
      r.x = PB'(rx);
      r.y = PB'(ry);
      r.heading = HW'(wrapped);
      r.clipped = clipped;
      return r;
   endfunction

   task automatic compare_field(string field, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      mismatch_count = 0;
      poses_in_flight = 0;
      results_checked = 0;
      results_clipped = 0;
   end

   always @(posedge clock) begin
      pose_result_type want;
      if (reset) begin
         expected_poses.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_poses.size() == 0) begin
               $error("result word with no pose waiting: x %0d y %0d heading %0d",
                      rsp_out_x, rsp_out_y, rsp_out_heading);
               mismatch_count++;
            end else begin
               want = expected_poses.pop_front();
               compare_field("out_x", want.x, rsp_out_x);
               compare_field("out_y", want.y, rsp_out_y);
               compare_field("out_heading", want.heading, rsp_out_heading);
               compare_field("saturated", want.clipped, rsp_saturated);
               results_checked++;
               if (want.clipped)
                  results_clipped++;
            end
         end
         if (start && !busy) begin
            expected_poses.push_back(transform_pose(ppft_pkg::kind_type'(req_kind),
               req_base_x, req_base_y, req_base_heading,
               req_pt_x, req_pt_y, req_pt_heading));
         end
      end
      poses_in_flight = expected_poses.size();
   end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Pose transform core testbench
// Drives poses into the planar pose frame transform core: a directed set of
// heading quadrants, half turns and saturating positions in both directions,
// then randomly shaped poses with bursts of idle cycles. The checker beside the
// core predicts and compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PB = ppft_pkg::POS_BITS;
   localparam int AB = ppft_pkg::ANGLE_BITS;
   localparam int HW = ppft_pkg::HW;

   localparam int RANDOM_POSES = 950;
   localparam int CALM_TAIL    = 150;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic signed [PB-1:0] POS_MAX  = {1'b0, {(PB-1){1'b1}}};
   localparam logic signed [PB-1:0] POS_MIN  = {1'b1, {(PB-1){1'b0}}};
   localparam logic signed [PB-1:0] POS_ONE  = 32'sh0001_0000;
   localparam logic signed [AB-1:0] QUARTER  = 16'sh4000;
   localparam logic signed [AB-1:0] EIGHTH   = 16'sh2000;
   localparam logic signed [AB-1:0] HALF     = 16'sh8000;
   localparam logic signed [AB-1:0] HEAD_MAX = 16'sh7FFF;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_kind;
   logic signed [PB-1:0] req_base_x;
   logic signed [PB-1:0] req_base_y;
   logic signed [AB-1:0] req_base_heading;
   logic signed [PB-1:0] req_pt_x;
   logic signed [PB-1:0] req_pt_y;
   logic signed [AB-1:0] req_pt_heading;
   logic                 rsp_valid;
   logic signed [PB-1:0] rsp_out_x;
   logic signed [PB-1:0] rsp_out_y;
   logic signed [HW-1:0] rsp_out_heading;
   logic                 rsp_saturated;

   int mismatch_count;
   int poses_in_flight;
   int results_checked;
   int results_clipped;
   int poses_sent;
   int inverse_sent;
   int cycle_count;

   planar_pose_frame_transform_core DUT (.*);

   pose_transform_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   // with start still high.
   task automatic issue_pose(ppft_pkg::kind_type kind,
                             logic signed [PB-1:0] bx,
                             logic signed [PB-1:0] by,
                             logic signed [AB-1:0] bh,
                             logic signed [PB-1:0] px,
                             logic signed [PB-1:0] py,
                             logic signed [AB-1:0] ph);
      start <= 1'b1;
      req_kind <= kind;
      req_base_x <= bx;
      req_base_y <= by;
      req_base_heading <= bh;
      req_pt_x <= px;
      req_pt_y <= py;
      req_pt_heading <= ph;
      do @(posedge clock); while (busy !== 1'b0);
      poses_sent++;
      if (kind == ppft_pkg::KIND_TO_BASE)
         inverse_sent++;
      @(negedge clock);
   endtask

   // Idle fields carry noise that the core must ignore.
   task automatic idle_cycles(int n);
      start <= 1'b0;
      req_kind <= 1'($urandom);
      req_base_x <= PB'($urandom);
      req_base_y <= PB'($urandom);
      req_base_heading <= AB'($urandom);
      req_pt_x <= PB'($urandom);
      req_pt_y <= PB'($urandom);
      req_pt_heading <= AB'($urandom);
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (poses_in_flight != 0) @(negedge clock);
   endtask

   function automatic logic signed [PB-1:0] random_position();
      logic signed [PB-1:0] v;
      case ($urandom_range(0, 4))
         0: v = PB'($urandom);
         4: begin
            case ($urandom_range(0, 4))
               0: v = POS_MAX;
               1: v = POS_MIN;
               2: v = '0;
               3: v = '1;
               default: v = POS_ONE;
            endcase
         end
         default: begin
            v = PB'($urandom);
            v = v >>> $urandom_range(2, 30);
         end
      endcase
      return v;
   endfunction

   function automatic logic signed [AB-1:0] random_heading();
      logic signed [AB-1:0] h;
      h = AB'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 6))
            0: h = '0;
            1: h = QUARTER;
            2: h = -QUARTER;
            3: h = HALF;
            4: h = HEAD_MAX;
            5: h = EIGHTH;
            default: h = -EIGHTH;
         endcase
      end
      return h;
   endfunction

   initial begin
      bit calm;
      reset = 1'b1;
      start = 1'b0;
      req_kind = 1'b0;
      req_base_x = '0;
      req_base_y = '0;
      req_base_heading = '0;
      req_pt_x = '0;
      req_pt_y = '0;
      req_pt_heading = '0;
      poses_sent = 0;
      inverse_sent = 0;
      cycle_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue_pose(ppft_pkg::KIND_TO_WORLD, '0, '0, '0, '0, '0, '0);
      issue_pose(ppft_pkg::KIND_TO_BASE, '0, '0, '0, '0, '0, '0);
      issue_pose(ppft_pkg::KIND_TO_WORLD, POS_ONE, -POS_ONE, QUARTER, POS_ONE, '0,
                 16'sd100);
      issue_pose(ppft_pkg::KIND_TO_WORLD, 32'sh0003_8000, '0, HALF, POS_ONE,
                 2 * POS_ONE, '0);
      issue_pose(ppft_pkg::KIND_TO_WORLD, '0, '0, -QUARTER, POS_ONE, POS_ONE, -QUARTER);
      issue_pose(ppft_pkg::KIND_TO_WORLD, '0, '0, EIGHTH, POS_ONE, POS_ONE, '0);
      issue_pose(ppft_pkg::KIND_TO_WORLD, '0, '0, -EIGHTH, POS_ONE, -POS_ONE, '0);
      issue_pose(ppft_pkg::KIND_TO_WORLD, '0, '0, HEAD_MAX, 7, -3, HEAD_MAX);
      issue_pose(ppft_pkg::KIND_TO_WORLD, '0, '0, QUARTER, '0, '0, QUARTER);
      issue_pose(ppft_pkg::KIND_TO_BASE, POS_ONE, POS_ONE, '0, '0, '0, HALF);
      issue_pose(ppft_pkg::KIND_TO_BASE, '0, '0, HALF, POS_ONE, '0, HALF);
      issue_pose(ppft_pkg::KIND_TO_WORLD, POS_MAX, POS_MAX, '0, POS_MAX, POS_MAX, '0);
      issue_pose(ppft_pkg::KIND_TO_WORLD, POS_MIN, POS_MIN, '0, POS_MIN, POS_MIN, '0);
      issue_pose(ppft_pkg::KIND_TO_BASE, POS_MAX, '0, '0, POS_MIN, '0, '0);
      issue_pose(ppft_pkg::KIND_TO_BASE, POS_MIN, POS_MAX, EIGHTH, POS_MAX, POS_MIN,
                 HALF);
      issue_pose(ppft_pkg::KIND_TO_WORLD, '1, '1, '1, '1, '1, '1);
      issue_pose(ppft_pkg::KIND_TO_BASE, '1, '1, '1, '1, '1, '1);
      issue_pose(ppft_pkg::KIND_TO_WORLD, '0, '0, 16'sd1, POS_MAX, POS_MAX, '0);
      issue_pose(ppft_pkg::KIND_TO_BASE, POS_ONE, -POS_ONE, 16'sh4001, 1, -1,
                 -HEAD_MAX);
      drain_results();

      for (int n = 0; n < RANDOM_POSES; n++) begin
         if (n == RANDOM_POSES / 2)
            drain_results();
         issue_pose(ppft_pkg::kind_type'($urandom_range(0, 1)), random_position(),
                    random_position(), random_heading(), random_position(),
                    random_position(), random_heading());
         calm = ((n / 64) % 3 == 0) || (n >= RANDOM_POSES - CALM_TAIL);
         if (!calm && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 11));
      end

      start <= 1'b0;
      while (poses_in_flight != 0) @(negedge clock);
      repeat (ppft_pkg::LATENCY + 4) @(negedge clock);

      $display("Sent %0d poses (%0d world-to-base) and compared %0d result words,",
               poses_sent, inverse_sent, results_checked);
      $display("%0d of them with clipped positions.", results_clipped);
      if (mismatch_count == 0 && poses_in_flight == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/ppft_pkg.sv
rtl/ppft_prep.sv
rtl/ppft_cordic_cell.sv
rtl/ppft_post.sv
rtl/planar_pose_frame_transform_core.sv
test/pose_transform_checker.sv
test/tb_top.sv
